[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr) \
  `ASSERT_PROP(lbl, !(expr))

`endif

[rtl/core/ppmr_pkg.sv]
// ---------------------------------------------------------------------------
// ppmr_pkg
// Types and constants of the pulse position motor ramp block.
// ---------------------------------------------------------------------------
package ppmr_pkg;

  localparam int unsigned TargetW   = 24;
  localparam int unsigned RampW     = 23;
  localparam int unsigned DutyW     = 8;
  localparam int unsigned FuncW     = 2;
  localparam int unsigned DirW      = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned QuotSteps = 8;
  localparam int unsigned StepCntW  = 3;

  localparam logic [DutyW-1:0] DutyFull = 8'hFF;

  typedef enum logic [FuncW-1:0] {
    FUNC_PULSE = 2'd0,
    FUNC_MOVE  = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_MARK  = 2'd3
  } func_e;

  typedef enum logic [DirW-1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REF_POS  = 3'd0,
    CFG_RAMP     = 3'd1,
    CFG_SMOOTH   = 3'd2,
    CFG_AUTO_REF = 3'd3,
    CFG_MIN_DUTY = 3'd4
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_DIST = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  typedef struct packed {
    logic             start;
    logic [RampW-1:0] dist_mag;
    logic [RampW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DutyW-1:0] quot;
  } div_rsp_t;

endpackage

[rtl/core/ppmr_if.sv]
// ---------------------------------------------------------------------------
// ppmr interfaces
// Valid/ready channels for configuration, input requests and results.
// ---------------------------------------------------------------------------
interface ppmr_cfg_if import ppmr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface ppmr_item_if import ppmr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FuncW-1:0]   func;
  logic               ref_level;
  logic [TargetW-1:0] target;

  modport source (output valid, func, ref_level, target, input ready);
  modport sink   (input valid, func, ref_level, target, output ready);
endinterface

interface ppmr_result_if import ppmr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DirW-1:0]    direction;
  logic [DutyW-1:0]   duty;
  logic [TargetW-1:0] position;

  modport source (output valid, direction, duty, position, input ready);
  modport sink   (input valid, direction, duty, position, output ready);
endinterface

[rtl/core/ppmr_div.sv]
// ---------------------------------------------------------------------------
// ppmr_div
// Restoring divider, one compare-subtract per cycle: floor(dist*255/divisor)
// for dist <= divisor, eight quotient bits.
// ---------------------------------------------------------------------------
module ppmr_div import ppmr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [RampW-1:0]       rem_q, rem_d;
  logic [RampW-1:0]       dvs_q, dvs_d;
  logic [DutyW-1:0]       qn_q, qn_d;
  logic [StepCntW-1:0]    cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [RampW+DutyW-1:0] num;
  logic [RampW:0]         trial;

  always_comb begin
    num    = {req_i.dist_mag, DutyW'(0)} - (RampW + DutyW)'(req_i.dist_mag);
    trial  = {rem_q, qn_q[DutyW-1]};
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    qn_d   = qn_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = num[RampW+DutyW-1:DutyW];
      qn_d   = num[DutyW-1:0];
      dvs_d  = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = RampW'(trial - {1'b0, dvs_q});
        qn_d  = {qn_q[DutyW-2:0], 1'b1};
      end else begin
        rem_d = trial[RampW-1:0];
        qn_d  = {qn_q[DutyW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == StepCntW'(QuotSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    qn_q  <= qn_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = qn_q;

endmodule

[rtl/core/pulse_position_motor_ramp.sv]
// ---------------------------------------------------------------------------
// pulse_position_motor_ramp
// Pulse-counted DC motor position drive with duty ramping near start/target.
// ---------------------------------------------------------------------------
// One request at a time: move, stop, mark-referenced and unsmoothed pulse
// requests pass through EXEC and RESP; a pulse with smoothing on also passes
// through DIST and, inside the ramp zone, through DIV, which waits out the
// eight compare-subtract steps of the shared duty divider. The result sits
// in an output register, so a new request is taken while it waits to be read.
// Positions are POSITION_WIDTH-bit two's complement and wrap; the position
// field shows the low 24 bits.
`include "assert_macros.svh"

module pulse_position_motor_ramp import ppmr_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ppmr_cfg_if.sink       cfg_i,
  ppmr_item_if.sink      item_i,
  ppmr_result_if.source  result_o
);

  localparam int unsigned CmpW = (POSITION_WIDTH > RampW) ? POSITION_WIDTH : RampW;

  typedef logic [POSITION_WIDTH-1:0] pos_t;

  function automatic pos_t abs_diff(pos_t a, pos_t b);
    pos_t d;
    d = a - b;
    return d[POSITION_WIDTH-1] ? pos_t'(-d) : d;
  endfunction

  // configuration
  logic [TargetW-1:0] ref_pos_q;
  logic [RampW-1:0]   ramp_q;
  logic               smooth_q;
  logic               auto_en_q;
  logic [DutyW-1:0]   min_duty_q;

  // request
  func_e              func_q;
  logic               lvl_q;
  logic [TargetW-1:0] tgt_in_q;

  // drive state
  state_e           state_q, state_d;
  pos_t             pos_q, pos_d;
  pos_t             tgt_q, tgt_d;
  pos_t             start_q, start_d;
  dir_e             dir_q, dir_d;
  logic             cnt_neg_q, cnt_neg_d;
  logic [DutyW-1:0] duty_q, duty_d;
  logic             slow_armed_q, slow_armed_d;
  logic             auto_armed_q, auto_armed_d;
  logic             last_lvl_q, last_lvl_d;

  // result
  logic               out_valid_q;
  logic [DirW-1:0]    out_dir_q;
  logic [DutyW-1:0]   out_duty_q;
  logic [TargetW-1:0] out_pos_q;
  logic               load_out;

  logic [RampW-1:0] ramp_eff;
  pos_t             ref_p, item_tgt_p, step_pos, tick_pos;
  pos_t             dc_abs, ds_abs;
  logic             dc_near, ds_near, snap, reached;
  dir_e             move_dir;
  logic [DutyW-1:0] ramp_duty;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_pos_q  <= '0;
      ramp_q     <= RampW'(1);
      smooth_q   <= 1'b0;
      auto_en_q  <= 1'b0;
      min_duty_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_REF_POS:  ref_pos_q  <= cfg_i.data[TargetW-1:0];
        CFG_RAMP:     ramp_q     <= cfg_i.data[RampW-1:0];
        CFG_SMOOTH:   smooth_q   <= cfg_i.data[0];
        CFG_AUTO_REF: auto_en_q  <= cfg_i.data[0];
        CFG_MIN_DUTY: min_duty_q <= cfg_i.data[DutyW-1:0];
        default: ;
      endcase
    end
  end

  assign item_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      func_q   <= func_e'(item_i.func);
      lvl_q    <= item_i.ref_level;
      tgt_in_q <= item_i.target;
    end
  end

  assign ramp_eff   = (ramp_q == '0) ? RampW'(1) : ramp_q;
  assign ref_p      = pos_t'($signed(ref_pos_q));
  assign item_tgt_p = pos_t'($signed(tgt_in_q));
  assign step_pos   = cnt_neg_q ? pos_q - 1'b1 : pos_q + 1'b1;
  assign snap       = auto_en_q && auto_armed_q && (last_lvl_q != lvl_q);
  assign tick_pos   = snap ? ref_p : step_pos;
  assign reached    = (dir_q == DIR_NONE)
                   || (dir_q == DIR_POS && $signed(tick_pos) >= $signed(tgt_q))
                   || (dir_q == DIR_NEG && $signed(tick_pos) <= $signed(tgt_q));
  assign move_dir   = ($signed(item_tgt_p) > $signed(pos_q)) ? DIR_POS : DIR_NEG;
  assign dc_abs     = abs_diff(pos_q, tgt_q);
  assign ds_abs     = abs_diff(pos_q, start_q);
  assign dc_near    = CmpW'(dc_abs) <= CmpW'(ramp_eff);
  assign ds_near    = CmpW'(ds_abs) <= CmpW'(ramp_eff);
  assign ramp_duty  = (div_rsp.quot < min_duty_q) ? min_duty_q : div_rsp.quot;

  always_comb begin
    state_d          = state_q;
    pos_d            = pos_q;
    tgt_d            = tgt_q;
    start_d          = start_q;
    dir_d            = dir_q;
    cnt_neg_d        = cnt_neg_q;
    duty_d           = duty_q;
    slow_armed_d     = slow_armed_q;
    auto_armed_d     = auto_armed_q;
    last_lvl_d       = last_lvl_q;
    div_req.start    = 1'b0;
    div_req.dist_mag = RampW'(dc_abs);
    div_req.divisor  = ramp_eff;
    case (state_q)
      ST_IDLE: begin
        if (item_i.valid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_RESP;
        case (func_q)
          FUNC_PULSE: begin
            pos_d = tick_pos;
            if (auto_en_q && auto_armed_q) last_lvl_d = lvl_q;
            if (reached) begin
              dir_d  = DIR_NONE;
              duty_d = '0;
            end
            if (smooth_q) state_d = ST_DIST;
          end
          FUNC_MOVE: begin
            tgt_d = item_tgt_p;
            if (item_tgt_p == pos_q) begin
              dir_d  = DIR_NONE;
              duty_d = '0;
            end else begin
              if (dir_q == DIR_NONE) begin
                start_d      = pos_q;
                slow_armed_d = 1'b1;
              end
              if (dir_q != move_dir) begin
                dir_d     = move_dir;
                cnt_neg_d = (move_dir == DIR_NEG);
                duty_d    = DutyFull;
              end
            end
          end
          FUNC_STOP: begin
            tgt_d  = pos_q;
            dir_d  = DIR_NONE;
            duty_d = '0;
          end
          FUNC_MARK: begin
            pos_d        = ref_p;
            last_lvl_d   = lvl_q;
            auto_armed_d = 1'b1;
          end
          default: ;
        endcase
      end
      ST_DIST: begin
        if (dc_near) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end else if (ds_near && slow_armed_q) begin
          div_req.start    = 1'b1;
          div_req.dist_mag = RampW'(ds_abs);
          state_d          = ST_DIV;
        end else begin
          slow_armed_d = 1'b0;
          state_d      = ST_RESP;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (dir_q != DIR_NONE) duty_d = ramp_duty;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || result_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pos_q        <= '0;
      tgt_q        <= '0;
      start_q      <= '0;
      dir_q        <= DIR_NONE;
      cnt_neg_q    <= 1'b0;
      duty_q       <= '0;
      slow_armed_q <= 1'b0;
      auto_armed_q <= 1'b0;
      last_lvl_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      tgt_q        <= tgt_d;
      start_q      <= start_d;
      dir_q        <= dir_d;
      cnt_neg_q    <= cnt_neg_d;
      duty_q       <= duty_d;
      slow_armed_q <= slow_armed_d;
      auto_armed_q <= auto_armed_d;
      last_lvl_q   <= last_lvl_d;
    end
  end

  ppmr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign load_out = (state_q == ST_RESP) && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_dir_q  <= dir_q;
      out_duty_q <= (dir_q == DIR_NONE) ? '0 : duty_q;
      out_pos_q  <= TargetW'(pos_q);
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.direction = out_dir_q;
  assign result_o.duty      = out_duty_q;
  assign result_o.position  = out_pos_q;

  `ASSERT_PROP(a_accept_exec, item_i.valid && item_i.ready |=> state_q == ST_EXEC)
  `ASSERT_PROP(a_done_in_div, div_rsp.done |-> state_q == ST_DIV)
  `ASSERT_PROP(a_none_no_duty, out_valid_q && out_dir_q == DIR_NONE |-> out_duty_q == '0)
  `ASSERT_NEVER(a_ready_div_busy, item_i.ready && div_rsp.done)

endmodule
